// ===== rtl/bcp_pkg.sv =====
`timescale 1ns / 1ps

package bcp_pkg;

  // Default build values of the top-level parameters.
  localparam int SCREEN_SIZE_DEF = 512;
  localparam int T_FRAC_BITS_DEF = 10;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 40;
  localparam int COORD_W   = 9;
  localparam int T_W       = 11;
  localparam int PT_W      = 11;

  // Sequencer step counter.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Operand register codes, shared by the sequencer and the lerp pipeline.
  typedef logic [4:0] reg_sel_t;
  localparam reg_sel_t REG_P0X = 5'd0;
  localparam reg_sel_t REG_P0Y = 5'd1;
  localparam reg_sel_t REG_HX  = 5'd2;
  localparam reg_sel_t REG_HY  = 5'd3;
  localparam reg_sel_t REG_P2X = 5'd4;
  localparam reg_sel_t REG_P2Y = 5'd5;
  localparam reg_sel_t REG_P3X = 5'd6;
  localparam reg_sel_t REG_P3Y = 5'd7;
  localparam reg_sel_t REG_Q0X = 5'd8;
  localparam reg_sel_t REG_Q0Y = 5'd9;
  localparam reg_sel_t REG_Q1X = 5'd10;
  localparam reg_sel_t REG_Q1Y = 5'd11;
  localparam reg_sel_t REG_Q2X = 5'd12;
  localparam reg_sel_t REG_Q2Y = 5'd13;
  localparam reg_sel_t REG_R0X = 5'd14;
  localparam reg_sel_t REG_R0Y = 5'd15;
  localparam reg_sel_t REG_R1X = 5'd16;
  localparam reg_sel_t REG_R1Y = 5'd17;
  localparam reg_sel_t REG_BX  = 5'd18;
  localparam reg_sel_t REG_BY  = 5'd19;

  // Datapath operations.
  typedef logic [1:0] op_t;
  localparam op_t OP_NOP  = 2'd0;
  localparam op_t OP_LERP = 2'd1;
  localparam op_t OP_FIX  = 2'd2;
  localparam op_t OP_OUT  = 2'd3;

  // Sequencing: advance, or hold until the output register is free and retire.
  typedef logic nxt_t;
  localparam nxt_t NXT_INC    = 1'b0;
  localparam nxt_t NXT_RETIRE = 1'b1;

  typedef struct packed {
    op_t      op;
    nxt_t     nxt;
    reg_sel_t src_a;
    reg_sel_t src_b;
    reg_sel_t dst;
  } ucode_t;

  // Issue into the lerp pipeline, and its write-back.
  typedef struct packed {
    logic     valid;
    reg_sel_t dst;
  } issue_t;

  typedef struct packed {
    logic     valid;
    reg_sel_t dst;
  } wb_t;

  function automatic ucode_t lerp_uw(input reg_sel_t a, input reg_sel_t b, input reg_sel_t d);
    ucode_t w;
    w.op    = OP_LERP;
    w.nxt   = NXT_INC;
    w.src_a = a;
    w.src_b = b;
    w.dst   = d;
    return w;
  endfunction

  function automatic ucode_t ctrl_uw(input op_t o, input nxt_t n);
    ucode_t w;
    w.op    = o;
    w.nxt   = n;
    w.src_a = REG_P0X;
    w.src_b = REG_P0X;
    w.dst   = REG_P0X;
    return w;
  endfunction

  // Control store. A lerp result is read only after it has left the pipeline and
  // been written back; idle steps cover the remaining gaps.
  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    unique case (step)
      5'd0:    w = lerp_uw(REG_P0X, REG_HX,  REG_Q0X);
      5'd1:    w = lerp_uw(REG_P0Y, REG_HY,  REG_Q0Y);
      5'd2:    w = lerp_uw(REG_HX,  REG_P2X, REG_Q1X);
      5'd3:    w = lerp_uw(REG_HY,  REG_P2Y, REG_Q1Y);
      5'd4:    w = lerp_uw(REG_P2X, REG_P3X, REG_Q2X);
      5'd5:    w = lerp_uw(REG_P2Y, REG_P3Y, REG_Q2Y);
      5'd6:    w = lerp_uw(REG_Q0X, REG_Q1X, REG_R0X);
      5'd7:    w = lerp_uw(REG_Q0Y, REG_Q1Y, REG_R0Y);
      5'd8:    w = lerp_uw(REG_Q1X, REG_Q2X, REG_R1X);
      5'd9:    w = lerp_uw(REG_Q1Y, REG_Q2Y, REG_R1Y);
      5'd10:   w = ctrl_uw(OP_NOP, NXT_INC);
      5'd11:   w = ctrl_uw(OP_NOP, NXT_INC);
      5'd12:   w = lerp_uw(REG_R0X, REG_R1X, REG_BX);
      5'd13:   w = lerp_uw(REG_R0Y, REG_R1Y, REG_BY);
      5'd14:   w = ctrl_uw(OP_NOP, NXT_INC);
      5'd15:   w = ctrl_uw(OP_NOP, NXT_INC);
      5'd16:   w = ctrl_uw(OP_NOP, NXT_INC);
      5'd17:   w = ctrl_uw(OP_FIX, NXT_INC);
      5'd18:   w = ctrl_uw(OP_OUT, NXT_RETIRE);
      default: w = ctrl_uw(OP_NOP, NXT_INC);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/bcp_lerp_unit.sv =====
`timescale 1ns / 1ps

// Three-stage lerp pipeline: t*a + (one - t)*b computed as (b << F) + t*(a - b).
module bcp_lerp_unit #(
  parameter int T_FRAC_BITS = bcp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [T_FRAC_BITS:0]              t,
  input  bcp_pkg::issue_t                   issue,
  input  logic signed [12+3*T_FRAC_BITS-1:0] a,
  input  logic signed [12+3*T_FRAC_BITS-1:0] b,
  output bcp_pkg::wb_t                      wb,
  output logic signed [12+3*T_FRAC_BITS-1:0] res
);
  import bcp_pkg::*;

  localparam int F  = T_FRAC_BITS;
  localparam int TW = F + 1;
  localparam int AW = 12 + 3 * F;
  localparam int DW = 12 + 2 * F;
  localparam int PW = TW + 1 + DW;

  logic signed [AW-1:0] diff_full;
  logic signed [PW-1:0] prod_full;
  logic signed [DW-1:0] diff_r;
  logic signed [AW-1:0] base1_r;
  logic signed [AW-1:0] base2_r;
  logic signed [AW-1:0] prod_r;
  logic signed [AW-1:0] res_r;
  issue_t               s1;
  issue_t               s2;
  issue_t               s3;

  // Operand difference; lerp inputs never exceed the second level, so it fits DW.
  assign diff_full = a - b;
  assign prod_full = $signed({1'b0, t}) * diff_r;

  // Tag pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else begin
      s1 <= issue;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // Data pipeline: subtract, multiply, accumulate.
  always_ff @(posedge clk) begin
    diff_r  <= diff_full[DW-1:0];
    base1_r <= b <<< F;
    prod_r  <= prod_full[AW-1:0];
    base2_r <= base1_r;
    res_r   <= base2_r + prod_r;
  end

  assign wb.valid = s3.valid;
  assign wb.dst   = s3.dst;
  assign res      = res_r;

endmodule

// ===== rtl/cubic_bezier_point_plotter.sv =====
`timescale 1ns / 1ps
// The result is loaded into the output register at the last step of the control program.
// The 19-step control program drives twelve lerps through the single shared multiply
// pipeline; a new item is accepted only after the previous one has retired.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous) clears the sequencer, output valid and stored handle.
module cubic_bezier_point_plotter #(
  parameter int SCREEN_SIZE = bcp_pkg::SCREEN_SIZE_DEF,
  parameter int T_FRAC_BITS = bcp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_param, zero pad
  input  logic [bcp_pkg::S_TDATA_W-1:0] s_tdata,
  // first_segment
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // curve_x, curve_y, pixel_row, zero pad
  output logic [bcp_pkg::M_TDATA_W-1:0] m_tdata,
  // in_window
  output logic                          m_tuser
);
  import bcp_pkg::*;

  localparam int F  = T_FRAC_BITS;
  localparam int TW = F + 1;
  localparam int AW = 12 + 3 * F;
  localparam int FW = 3 * F;
  localparam int CW = (F + 2 > 12) ? F + 2 : 12;
  localparam int SW = $clog2(SCREEN_SIZE) + 1;
  localparam int RW = (SW + 1 > 12) ? SW + 1 : 12;
  localparam logic [CW-1:0]        ONE_C  = CW'(1) << F;
  localparam logic signed [RW-1:0] SCRN_S = RW'(SCREEN_SIZE);

  // Input fields.
  logic [COORD_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic [T_W-1:0]     t_param;
  logic [CW-1:0]      t_ext;
  logic [TW-1:0]      t_in_sat;

  // Control state.
  logic   busy;
  step_t  step;
  logic   out_valid;
  ucode_t uw;
  logic   in_acc;
  logic   out_free;
  logic   do_out;

  // Stored reflected handle.
  logic signed [PT_W-1:0] handle_x, handle_y;
  logic signed [PT_W-1:0] hx_in, hy_in;

  // Operand registers.
  logic [TW-1:0]        t_sat;
  logic signed [AW-1:0] p0x, p0y, hx, hy, p2x, p2y, p3x, p3y;
  logic signed [AW-1:0] q0x, q0y, q1x, q1y, q2x, q2y, r0x, r0y, r1x, r1y, bx, by;
  logic signed [AW-1:0] opa, opb;

  // Lerp pipeline connections.
  issue_t               issue;
  wb_t                  wb;
  logic signed [AW-1:0] wb_res;

  // Result registers.
  logic signed [PT_W-1:0] cx, cy;
  logic signed [RW-1:0]   row_w;
  logic signed [RW-1:0]   cx_w;
  logic                   win_w;
  logic [PT_W-1:0]        out_x, out_y, out_row;
  logic                   out_win;

  assign p0_x    = s_tdata[8:0];
  assign p0_y    = s_tdata[17:9];
  assign p1_x    = s_tdata[26:18];
  assign p1_y    = s_tdata[35:27];
  assign p2_x    = s_tdata[44:36];
  assign p2_y    = s_tdata[53:45];
  assign p3_x    = s_tdata[62:54];
  assign p3_y    = s_tdata[71:63];
  assign t_param = s_tdata[82:72];

  // A parameter above one is held at one.
  assign t_ext    = CW'(t_param);
  assign t_in_sat = (t_ext > ONE_C) ? ONE_C[TW-1:0] : t_ext[TW-1:0];

  // First segment uses p1 as handle, later ones the stored reflection.
  assign hx_in = s_tuser ? $signed({2'b00, p1_x}) : handle_x;
  assign hy_in = s_tuser ? $signed({2'b00, p1_y}) : handle_y;

  assign s_tready = !busy;
  assign in_acc   = s_tvalid && s_tready;
  assign uw       = ucode(step);
  assign out_free = !out_valid || m_tready;
  assign do_out   = busy && (uw.op == OP_OUT) && out_free;

  // Operand selection for the lerp pipeline.
  always_comb begin
    case (uw.src_a)
      REG_P0X: opa = p0x;
      REG_P0Y: opa = p0y;
      REG_HX:  opa = hx;
      REG_HY:  opa = hy;
      REG_P2X: opa = p2x;
      REG_P2Y: opa = p2y;
      REG_P3X: opa = p3x;
      REG_P3Y: opa = p3y;
      REG_Q0X: opa = q0x;
      REG_Q0Y: opa = q0y;
      REG_Q1X: opa = q1x;
      REG_Q1Y: opa = q1y;
      REG_Q2X: opa = q2x;
      REG_Q2Y: opa = q2y;
      REG_R0X: opa = r0x;
      REG_R0Y: opa = r0y;
      REG_R1X: opa = r1x;
      REG_R1Y: opa = r1y;
      default: opa = '0;
    endcase
    case (uw.src_b)
      REG_P0X: opb = p0x;
      REG_P0Y: opb = p0y;
      REG_HX:  opb = hx;
      REG_HY:  opb = hy;
      REG_P2X: opb = p2x;
      REG_P2Y: opb = p2y;
      REG_P3X: opb = p3x;
      REG_P3Y: opb = p3y;
      REG_Q0X: opb = q0x;
      REG_Q0Y: opb = q0y;
      REG_Q1X: opb = q1x;
      REG_Q1Y: opb = q1y;
      REG_Q2X: opb = q2x;
      REG_Q2Y: opb = q2y;
      REG_R0X: opb = r0x;
      REG_R0Y: opb = r0y;
      REG_R1X: opb = r1x;
      REG_R1Y: opb = r1y;
      default: opb = '0;
    endcase
  end

  assign issue.valid = busy && (uw.op == OP_LERP);
  assign issue.dst   = uw.dst;

  bcp_lerp_unit #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_lerp (
    .clk  (clk),
    .rst  (rst),
    .t    (t_sat),
    .issue(issue),
    .a    (opa),
    .b    (opb),
    .wb   (wb),
    .res  (wb_res)
  );

  // Drop the fraction bits, rounding toward zero.
  function automatic logic signed [PT_W-1:0] trunc_pt(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] q;
    q = v >>> FW;
    if (v[AW-1] && (v[FW-1:0] != '0)) begin
      q = q + AW'(1);
    end
    return q[PT_W-1:0];
  endfunction

  // Screen row and window test.
  always_comb begin
    cx_w  = RW'(cx);
    row_w = SCRN_S - RW'(cy);
    win_w = (cx_w >= 0) && (cx_w < SCRN_S) && (row_w >= 0) && (row_w < SCRN_S);
  end

  // Sequencer: step counter with hold-and-retire on the output step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      handle_x  <= '0;
      handle_y  <= '0;
    end else begin
      if (do_out) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        busy <= 1'b1;
        step <= '0;
        if (s_tlast) begin
          handle_x <= $signed({1'b0, p3_x, 1'b0}) - $signed({2'b00, p2_x});
          handle_y <= $signed({1'b0, p3_y, 1'b0}) - $signed({2'b00, p2_y});
        end
      end else if (busy) begin
        unique case (uw.nxt)
          NXT_INC: begin
            step <= step + STEP_W'(1);
          end
          NXT_RETIRE: begin
            if (out_free) begin
              busy <= 1'b0;
            end
          end
          default: begin
            step <= step;
          end
        endcase
      end
    end
  end

  // Operand loading at the input transaction.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_sat <= t_in_sat;
      p0x   <= AW'($signed({2'b00, p0_x}));
      p0y   <= AW'($signed({2'b00, p0_y}));
      hx    <= AW'(hx_in);
      hy    <= AW'(hy_in);
      p2x   <= AW'($signed({2'b00, p2_x}));
      p2y   <= AW'($signed({2'b00, p2_y}));
      p3x   <= AW'($signed({2'b00, p3_x}));
      p3y   <= AW'($signed({2'b00, p3_y}));
    end
  end

  // Write-back from the lerp pipeline.
  always_ff @(posedge clk) begin
    if (wb.valid) begin
      case (wb.dst)
        REG_Q0X: q0x <= wb_res;
        REG_Q0Y: q0y <= wb_res;
        REG_Q1X: q1x <= wb_res;
        REG_Q1Y: q1y <= wb_res;
        REG_Q2X: q2x <= wb_res;
        REG_Q2Y: q2y <= wb_res;
        REG_R0X: r0x <= wb_res;
        REG_R0Y: r0y <= wb_res;
        REG_R1X: r1x <= wb_res;
        REG_R1Y: r1y <= wb_res;
        REG_BX:  bx  <= wb_res;
        REG_BY:  by  <= wb_res;
        default: q0x <= q0x;
      endcase
    end
  end

  // Integer point, then the output register.
  always_ff @(posedge clk) begin
    if (busy && (uw.op == OP_FIX)) begin
      cx <= trunc_pt(bx);
      cy <= trunc_pt(by);
    end
    if (do_out) begin
      out_x   <= cx;
      out_y   <= cy;
      out_row <= row_w[PT_W-1:0];
      out_win <= win_w;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - 3 * PT_W)'(0), out_row, out_y, out_x};
  assign m_tuser  = out_win;

endmodule
